### rtl/swept_aabb_collision_defines.svh
// ----------------------------------------------------------------------------
// Swept box collision assertion macros
// Concurrent assertion helpers for the swept box collision block; empty
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SWEPT_AABB_COLLISION_DEFINES_SVH
`define SWEPT_AABB_COLLISION_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sac assertion failed");
// implication after a fixed number of cycles
`define SAC_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("sac latency assertion failed");
`else
`define SAC_ASSERT_IMP(lbl, ante, cons)
`define SAC_ASSERT_DLY(lbl, ante, n, cons)
`endif
`endif

### rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// Swept box collision package
// Shared constants for the swept box collision pipeline and its divider.
// ----------------------------------------------------------------------------
package sac_pkg;

  // quotient bits produced by each divider (quotient below 2^18 when not saturated)
  localparam int DIV_QBITS = 18;
  // default quotient bits per divider stage
  localparam int DIV_STEP_DEF = 2;

  // time constants, signed Q6.15 held in 22 bits
  localparam logic signed [21:0] TIME_ONE = 22'sd32768;
  localparam logic signed [21:0] TIME_SAT = 22'sd65536;
  localparam logic signed [21:0] TIME_INF = 22'sd1048576;

  // pipeline words carried alongside the dividers
  typedef struct packed {
    logic               broad;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               xin_neg;
    logic               yin_neg;
    logic [3:0]         neg;
    logic [3:0]         ovf;
  } side_t;

endpackage

### rtl/sac_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces an 18-bit quotient, STEP bits per register stage. The caller
// supplies the partial remainder already below the divisor.
// ----------------------------------------------------------------------------
module sac_div #(
  parameter int STEP = sac_pkg::DIV_STEP_DEF
) (
  input  logic                          clk,
  input  logic [15:0]                   rem_in,
  input  logic [sac_pkg::DIV_QBITS-1:0] num_in,
  input  logic [15:0]                   den_in,
  output logic [sac_pkg::DIV_QBITS-1:0] quo
);

  localparam int QB   = sac_pkg::DIV_QBITS;
  localparam int NSTG = QB / STEP;

  logic [15:0]   rem_r [NSTG];
  logic [QB-1:0] num_r [NSTG];
  logic [QB-1:0] quo_r [NSTG];
  logic [15:0]   den_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic [15:0]   rem_i;
    logic [QB-1:0] num_i;
    logic [QB-1:0] quo_i;
    logic [15:0]   den_i;
    logic [15:0]   rem_next;
    logic [QB-1:0] num_next;
    logic [QB-1:0] quo_next;

    if (k == 0) begin : g_first
      assign rem_i = rem_in;
      assign num_i = num_in;
      assign quo_i = '0;
      assign den_i = den_in;
    end else begin : g_rest
      assign rem_i = rem_r[k-1];
      assign num_i = num_r[k-1];
      assign quo_i = quo_r[k-1];
      assign den_i = den_r[k-1];
    end

    // STEP restoring steps
    always_comb begin
      logic [16:0] sh;
      logic        qb;
      rem_next = rem_i;
      num_next = num_i;
      quo_next = quo_i;
      for (int j = 0; j < STEP; j++) begin
        sh       = {rem_next, num_next[QB-1]};
        num_next = {num_next[QB-2:0], 1'b0};
        qb       = 1'b0;
        if (sh >= {1'b0, den_i}) begin
          sh = sh - {1'b0, den_i};
          qb = 1'b1;
        end
        rem_next = sh[15:0];
        quo_next = {quo_next[QB-2:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_next;
      num_r[k] <= num_next;
      quo_r[k] <= quo_next;
      den_r[k] <= den_i;
    end
  end

  assign quo = quo_r[NSTG-1];

endmodule

### rtl/swept_aabb_collision.sv
// ----------------------------------------------------------------------------
// Swept box collision, 2-D
// Swept broadphase test of a moving box against a static box, entry time,
// surface normal and advanced position, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   handshake        word
//  input     start / busy     mover_*, block_* box pair
//  result    done strobe      broad_hit, hit, hit_time, normal_*, new_*
//
//  One word enters per cycle; busy is never raised.
//  Each word runs through the four pipelined dividers between the operand and axis time stages.
//  rst (synchronous) clears only the valid bits; the pipeline then drains.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "swept_aabb_collision_defines.svh"

module swept_aabb_collision #(
  parameter int DIV_STEP = sac_pkg::DIV_STEP_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] mover_x,
  input  logic signed [15:0] mover_y,
  input  logic [14:0]        mover_w,
  input  logic [14:0]        mover_h,
  input  logic signed [15:0] mover_vx,
  input  logic signed [15:0] mover_vy,
  input  logic signed [15:0] block_x,
  input  logic signed [15:0] block_y,
  input  logic [14:0]        block_w,
  input  logic [14:0]        block_h,
  output logic               done,
  output logic               broad_hit,
  output logic               hit,
  output logic [15:0]        hit_time,
  output logic signed [1:0]  normal_x,
  output logic signed [1:0]  normal_y,
  output logic signed [15:0] new_x,
  output logic signed [15:0] new_y
);

  localparam int QB   = sac_pkg::DIV_QBITS;
  localparam int NSTG = QB / DIV_STEP;
  localparam int LAT  = NSTG + 7;

  assign busy = 1'b0;

  // stage 1: input registers
  logic v1;
  logic signed [15:0] x1, y1, vx1, vy1, bx1, by1;
  logic [14:0] w1, h1, bw1, bh1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    x1 <= mover_x;  y1 <= mover_y;  w1 <= mover_w;  h1 <= mover_h;
    vx1 <= mover_vx; vy1 <= mover_vy;
    bx1 <= block_x; by1 <= block_y; bw1 <= block_w; bh1 <= block_h;
  end

  // stage 2: edge distances and swept box extents
  logic v2;
  logic signed [17:0] xin2, xout2, yin2, yout2, xhi2, xlo2, yhi2, ylo2, bxr2, byb2;
  logic signed [15:0] x2, y2, vx2, vy2, bx2, by2;

  always_ff @(posedge clk) begin
    logic signed [17:0] xr, yb, bxr, byb;
    xr  = 18'(x1) + 18'(signed'({1'b0, w1}));
    yb  = 18'(y1) + 18'(signed'({1'b0, h1}));
    bxr = 18'(bx1) + 18'(signed'({1'b0, bw1}));
    byb = 18'(by1) + 18'(signed'({1'b0, bh1}));
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    if (vx1 > 0) begin
      xin2 <= 18'(bx1) - xr;  xout2 <= bxr - 18'(x1);
      xhi2 <= xr + 18'(vx1);  xlo2  <= 18'(x1);
    end else begin
      xin2 <= bxr - 18'(x1);  xout2 <= 18'(bx1) - xr;
      xhi2 <= xr;             xlo2  <= 18'(x1) + 18'(vx1);
    end
    if (vy1 > 0) begin
      yin2 <= 18'(by1) - yb;  yout2 <= byb - 18'(y1);
      yhi2 <= yb + 18'(vy1);  ylo2  <= 18'(y1);
    end else begin
      yin2 <= byb - 18'(y1);  yout2 <= 18'(by1) - yb;
      yhi2 <= yb;             ylo2  <= 18'(y1) + 18'(vy1);
    end
    bxr2 <= bxr; byb2 <= byb;
    x2 <= x1; y2 <= y1; vx2 <= vx1; vy2 <= vy1; bx2 <= bx1; by2 <= by1;
  end

  // stage 3: broadphase, magnitudes, saturation check, divider operands
  logic v3;
  sac_pkg::side_t side3;
  logic [15:0]   drem [4];
  logic [QB-1:0] dnum [4];
  logic [15:0]   dden [4];

  always_ff @(posedge clk) begin
    logic signed [17:0] edist [4];
    logic [16:0] ad;
    logic [15:0] av;
    logic signed [15:0] vel;
    edist[0] = xin2; edist[1] = xout2; edist[2] = yin2; edist[3] = yout2;
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    side3.broad <= !(xhi2 < 18'(bx2) || xlo2 > bxr2 || yhi2 < 18'(by2) || ylo2 > byb2);
    side3.x <= x2; side3.y <= y2; side3.vx <= vx2; side3.vy <= vy2;
    side3.xin_neg <= xin2[17];
    side3.yin_neg <= yin2[17];
    for (int i = 0; i < 4; i++) begin
      vel = (i < 2) ? vx2 : vy2;
      ad  = edist[i][17] ? 17'(-edist[i]) : edist[i][16:0];
      av  = vel[15] ? 16'(-vel) : 16'(vel);
      side3.neg[i] <= edist[i][17] ^ vel[15];
      side3.ovf[i] <= {2'b00, ad[16:3]} >= av;
      drem[i] <= {2'b00, ad[16:3]};
      dnum[i] <= {ad[2:0], 15'd0};
      dden[i] <= av;
    end
  end

  // dividers, four quotients per word
  logic [QB-1:0] quo [4];
  for (genvar i = 0; i < 4; i++) begin : g_div
    sac_div #(.STEP(DIV_STEP)) u_div (
      .clk    (clk),
      .rem_in (drem[i]),
      .num_in (dnum[i]),
      .den_in (dden[i]),
      .quo    (quo[i])
    );
  end

  // side words and valid bits travel with the divider stages
  logic           vd [NSTG];
  sac_pkg::side_t sd [NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) vd[k] <= 1'b0;
    end else begin
      vd[0] <= v3;
      for (int k = 1; k < NSTG; k++) vd[k] <= vd[k-1];
    end
    sd[0] <= side3;
    for (int k = 1; k < NSTG; k++) sd[k] <= sd[k-1];
  end

  // signed, saturated axis time
  function automatic logic signed [21:0] axis_time(logic [QB-1:0] q, logic ovf, logic neg);
    logic signed [21:0] m;
    m = (ovf || 22'(q) > sac_pkg::TIME_SAT) ? sac_pkg::TIME_SAT : 22'(q);
    return neg ? -m : m;
  endfunction

  // stage 4: axis entry and exit times
  logic v4;
  sac_pkg::side_t side4;
  logic signed [21:0] xe4, xx4, ye4, yx4;

  always_ff @(posedge clk) begin
    sac_pkg::side_t s;
    s = sd[NSTG-1];
    if (rst) v4 <= 1'b0;
    else     v4 <= vd[NSTG-1];
    side4 <= s;
    if (s.vx == 16'sd0) begin
      xe4 <= -sac_pkg::TIME_INF; xx4 <= sac_pkg::TIME_INF;
    end else begin
      xe4 <= axis_time(quo[0], s.ovf[0], s.neg[0]);
      xx4 <= axis_time(quo[1], s.ovf[1], s.neg[1]);
    end
    if (s.vy == 16'sd0) begin
      ye4 <= -sac_pkg::TIME_INF; yx4 <= sac_pkg::TIME_INF;
    end else begin
      ye4 <= axis_time(quo[2], s.ovf[2], s.neg[2]);
      yx4 <= axis_time(quo[3], s.ovf[3], s.neg[3]);
    end
  end

  // stage 5: collision decision, time and normal
  logic v5, broad5;
  logic [16:0] t5;
  logic signed [1:0] nx5, ny5;
  logic signed [15:0] x5, y5, vx5, vy5;

  always_ff @(posedge clk) begin
    logic signed [21:0] entry, exit_t;
    logic miss;
    entry  = (xe4 > ye4) ? xe4 : ye4;
    exit_t = (xx4 < yx4) ? xx4 : yx4;
    miss   = entry > exit_t || (xe4 < 0 && ye4 < 0) ||
             xe4 > sac_pkg::TIME_ONE || ye4 > sac_pkg::TIME_ONE;
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    broad5 <= side4.broad;
    x5 <= side4.x; y5 <= side4.y; vx5 <= side4.vx; vy5 <= side4.vy;
    t5  <= 17'(sac_pkg::TIME_ONE);
    nx5 <= 2'sd0;
    ny5 <= 2'sd0;
    if (side4.broad && !miss) begin
      t5 <= entry[16:0];
      if (xe4 > ye4) nx5 <= side4.xin_neg ? 2'sd1 : -2'sd1;
      else           ny5 <= side4.yin_neg ? 2'sd1 : -2'sd1;
    end
  end

  // stage 6: displacement times collision time
  logic v6, broad6;
  logic [16:0] t6;
  logic signed [1:0] nx6, ny6;
  logic signed [15:0] x6, y6;
  logic signed [33:0] px6, py6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    broad6 <= broad5; t6 <= t5; nx6 <= nx5; ny6 <= ny5; x6 <= x5; y6 <= y5;
    px6 <= 34'(vx5) * 34'(signed'({1'b0, t5}));
    py6 <= 34'(vy5) * 34'(signed'({1'b0, t5}));
  end

  // stage 7: round, advance, saturate, result registers
  function automatic logic signed [15:0] adv(logic signed [15:0] pos, logic signed [33:0] p);
    logic signed [33:0] r;
    logic signed [19:0] s;
    r = (p + 34'sd16384) >>> 15;
    s = 20'(pos) + r[19:0];
    if (s > 20'sd32767)       return 16'sh7fff;
    else if (s < -20'sd32768) return 16'sh8000;
    else                      return s[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v6;
    broad_hit <= broad6;
    hit       <= broad6 && (t6 < 17'(sac_pkg::TIME_ONE));
    hit_time  <= t6[15:0];
    normal_x  <= nx6;
    normal_y  <= ny6;
    new_x     <= broad6 ? adv(x6, px6) : x6;
    new_y     <= broad6 ? adv(y6, py6) : y6;
  end

  // checks
  `SAC_ASSERT_DLY(a_latency, start && !busy, LAT, done)
  `SAC_ASSERT_IMP(a_hit_broad, done && hit, broad_hit)
  `SAC_ASSERT_IMP(a_no_broad, done && !broad_hit, hit_time == 16'h8000 && normal_x == 2'sd0 && normal_y == 2'sd0)
  `SAC_ASSERT_IMP(a_hit_normal, done && hit, normal_x != 2'sd0 || normal_y != 2'sd0)

endmodule
